/* rtl/core/icd_pkg.sv */
// shared types, register indexes and helpers for the impedance current derating block
package icd_pkg;

    // fixed field widths
    localparam int IMP_W      = 16;
    localparam int CUR_W      = 16;
    localparam int CNT_W      = 3;
    localparam int WORD_W     = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int SLOT_W     = 16;
    localparam int SLOT_SEL_W = 2;

    // stream payload widths
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NODE_ACTIVE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_IMP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_DEF_CUR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_DEF_CUR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_COUNT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLDS    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_CURRENTS = 3'd6;

    // request kinds
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_REFILL = 1'b1;

    // configuration register contents
    typedef struct packed {
        logic                node_active;
        logic [IMP_W-1:0]    default_imp;
        logic [CUR_W-1:0]    node_default_cur;
        logic [CUR_W-1:0]    unit_default_cur;
        logic [CNT_W-1:0]    table_count;
        logic [WORD_W-1:0]   thr_words;
        logic [WORD_W-1:0]   step_cur_words;
    } cfg_t;

    // history update controls
    typedef struct packed {
        logic refill;
        logic push;
    } hist_ctl_t;

    // one 16-bit slot of a packed 64-bit word
    function automatic logic [SLOT_W-1:0] packed_field(input logic [WORD_W-1:0] word,
                                                       input logic [SLOT_SEL_W-1:0] slot);
        packed_field = word[slot*SLOT_W +: SLOT_W];
    endfunction

endpackage

/* rtl/core/icd_cfg.sv */
// configuration register file of the impedance current derating block
module icd_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [icd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [icd_pkg::WORD_W-1:0]    cfg_data,
    output icd_pkg::cfg_t                 cfg
);
    import icd_pkg::*;

    cfg_t cfg_reg;

    // writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_active      <= 1'b1;
            cfg_reg.default_imp      <= '0;
            cfg_reg.node_default_cur <= '0;
            cfg_reg.unit_default_cur <= '0;
            cfg_reg.table_count      <= '0;
            cfg_reg.thr_words        <= '0;
            cfg_reg.step_cur_words   <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_NODE_ACTIVE:   cfg_reg.node_active      <= cfg_data[0];
                REG_DEFAULT_IMP:   cfg_reg.default_imp      <= cfg_data[IMP_W-1:0];
                REG_NODE_DEF_CUR:  cfg_reg.node_default_cur <= cfg_data[CUR_W-1:0];
                REG_UNIT_DEF_CUR:  cfg_reg.unit_default_cur <= cfg_data[CUR_W-1:0];
                REG_TABLE_COUNT:   cfg_reg.table_count      <= cfg_data[CNT_W-1:0];
                REG_THRESHOLDS:    cfg_reg.thr_words        <= cfg_data;
                REG_STEP_CURRENTS: cfg_reg.step_cur_words   <= cfg_data;
                default:           ;
            endcase
        end
    end

endmodule

/* rtl/core/icd_hist.sv */
// sliding window of impedance readings with running sum
module icd_hist #(
    parameter int HISTORY_DEPTH = 8
)
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  icd_pkg::hist_ctl_t                          ctl,
    input  logic [icd_pkg::IMP_W-1:0]                   imp,
    input  logic [icd_pkg::IMP_W-1:0]                   default_imp,
    output logic [icd_pkg::IMP_W+$clog2(HISTORY_DEPTH)-1:0] sum_next
);
    import icd_pkg::*;

    localparam int SUM_W = IMP_W + $clog2(HISTORY_DEPTH);
    localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(HISTORY_DEPTH - 1);

    logic [IMP_W-1:0] mem [HISTORY_DEPTH];
    logic [PTR_W-1:0] wp_reg;
    logic [PTR_W-1:0] wp_next;
    logic             full_reg;
    logic             full_next;
    logic [IMP_W-1:0] refill_val_reg;
    logic [IMP_W-1:0] rd_reg;
    logic [IMP_W-1:0] oldest;
    logic [SUM_W-1:0] sum_reg;

    // entries not yet rewritten since the last refill still hold the refill value
    assign oldest = full_reg ? rd_reg : refill_val_reg;

    // next pointer, fill state and running sum
    always_comb
    begin
        wp_next   = wp_reg;
        full_next = full_reg;
        sum_next  = sum_reg;
        if (ctl.refill)
        begin
            wp_next   = '0;
            full_next = 1'b0;
            sum_next  = SUM_W'(default_imp) * SUM_W'(HISTORY_DEPTH);
        end
        else if (ctl.push)
        begin
            wp_next   = (wp_reg == LAST_POS) ? '0 : wp_reg + PTR_W'(1);
            full_next = full_reg | (wp_reg == LAST_POS);
            sum_next  = sum_reg - SUM_W'(oldest) + SUM_W'(imp);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg         <= '0;
            full_reg       <= 1'b0;
            sum_reg        <= '0;
            refill_val_reg <= '0;
        end
        else
        begin
            wp_reg   <= wp_next;
            full_reg <= full_next;
            sum_reg  <= sum_next;
            if (ctl.refill)
            begin
                refill_val_reg <= default_imp;
            end
        end
    end

    // history memory, read ahead at the next oldest entry with write bypass
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[wp_reg] <= imp;
        end
        if (ctl.push && (wp_next == wp_reg))
        begin
            rd_reg <= imp;
        end
        else
        begin
            rd_reg <= mem[wp_next];
        end
    end

endmodule

/* rtl/core/impedance_current_derating.sv */
// impedance current derating: window average of impedance readings mapped to a current limit
// path: an accepted sample request passes the input, s2, s3 and output registers in turn
// throughput: one request per cycle while the output register is not held, bounded by the running sum update
// the history window is updated as the request leaves the input register, so requests follow back to back
// reset: config regs take their defaults, history reads as zero with an empty window
// reset: all pipeline and skid valids are cleared, no clearing pass is needed
module impedance_current_derating #(
    parameter int HISTORY_DEPTH = 8,
    parameter int TABLE_ENTRIES = 4
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [15:0] impedance_mohm, [16] reading_ok, [23:17] zero
    input  logic [icd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [0] cmd
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [15:0] allowed_current_ma, [31:16] average_impedance_mohm, [32] reading_used,
    // [33] zero_limit, [39:34] zero
    output logic [icd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [icd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [icd_pkg::WORD_W-1:0]     cfg_data
);
    import icd_pkg::*;

    localparam int SUM_W      = IMP_W + $clog2(HISTORY_DEPTH);
    localparam int DIV_SH     = SUM_W + $clog2(HISTORY_DEPTH);
    localparam int MUL_W      = SUM_W + 1;
    localparam int PROD_W     = SUM_W + MUL_W;
    localparam int STEP_CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [MUL_W-1:0] DIV_M =
        MUL_W'(((64'd1 << DIV_SH) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));

    cfg_t      cfg;
    hist_ctl_t hist_ctl;

    logic             en;
    logic [SUM_W-1:0] sum_next;

    logic             skid_valid_reg;
    logic             skid_cmd_reg;
    logic [IMP_W-1:0] skid_imp_reg;
    logic             skid_ok_reg;

    logic             in_valid_reg;
    logic             in_cmd_reg;
    logic [IMP_W-1:0] in_imp_reg;
    logic             in_ok_reg;

    logic             s2_valid_reg;
    logic             s2_used_reg;
    logic [SUM_W-1:0] s2_sum_reg;

    logic             s3_valid_reg;
    logic             s3_used_reg;
    logic [IMP_W-1:0] s3_avg_reg;

    logic             out_valid_reg;
    logic [CUR_W-1:0] out_allowed_reg;
    logic [IMP_W-1:0] out_avg_reg;
    logic             out_used_reg;
    logic             out_zero_reg;

    logic [PROD_W-1:0]     prod;
    logic [STEP_CNT_W-1:0] steps;
    logic [STEP_CNT_W-1:0] sel_idx;
    logic [IMP_W:0]        bound;
    logic [CUR_W-1:0]      sel_cur;
    logic [CUR_W-1:0]      allowed;

    icd_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // pipeline advances unless the output register holds an untaken result
    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !skid_valid_reg;

    // input skid and input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
            in_valid_reg   <= 1'b0;
        end
        else if (en)
        begin
            skid_valid_reg <= 1'b0;
            in_valid_reg   <= skid_valid_reg || s_axis_tvalid;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!en && s_axis_tvalid && s_axis_tready)
        begin
            skid_cmd_reg <= s_axis_tuser;
            skid_imp_reg <= s_axis_tdata[IMP_W-1:0];
            skid_ok_reg  <= s_axis_tdata[IMP_W];
        end
        if (en)
        begin
            if (skid_valid_reg)
            begin
                in_cmd_reg <= skid_cmd_reg;
                in_imp_reg <= skid_imp_reg;
                in_ok_reg  <= skid_ok_reg;
            end
            else
            begin
                in_cmd_reg <= s_axis_tuser;
                in_imp_reg <= s_axis_tdata[IMP_W-1:0];
                in_ok_reg  <= s_axis_tdata[IMP_W];
            end
        end
    end

    // history update as the request leaves the input register
    assign hist_ctl.refill = en && in_valid_reg && (in_cmd_reg == CMD_REFILL);
    assign hist_ctl.push   = en && in_valid_reg && (in_cmd_reg == CMD_SAMPLE)
                             && cfg.node_active && in_ok_reg;

    icd_hist #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_hist
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (hist_ctl),
        .imp         (in_imp_reg),
        .default_imp (cfg.default_imp),
        .sum_next    (sum_next)
    );

    // average by reciprocal multiply, exact for every window sum
    assign prod = PROD_W'(s2_sum_reg) * PROD_W'(DIV_M);

    // step search: first step in use whose bound the average stays below
    always_comb
    begin
        bound = '0;
        if (cfg.table_count > CNT_W'(TABLE_ENTRIES))
        begin
            steps = STEP_CNT_W'(TABLE_ENTRIES);
        end
        else
        begin
            steps = STEP_CNT_W'(cfg.table_count);
        end
        sel_idx = steps;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            bound = {1'b0, cfg.default_imp}
                    + {1'b0, packed_field(cfg.thr_words, SLOT_SEL_W'(i))};
            if ((STEP_CNT_W'(i) < steps) && ({1'b0, s3_avg_reg} < bound))
            begin
                sel_idx = STEP_CNT_W'(i);
            end
        end
        if (sel_idx == '0)
        begin
            sel_cur = cfg.node_default_cur;
        end
        else
        begin
            sel_cur = packed_field(cfg.step_cur_words, SLOT_SEL_W'(sel_idx - STEP_CNT_W'(1)));
        end
        allowed = (sel_cur < cfg.unit_default_cur) ? sel_cur : cfg.unit_default_cur;
    end

    // pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg  <= in_valid_reg && (in_cmd_reg == CMD_SAMPLE);
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_used_reg <= hist_ctl.push;
            s2_sum_reg  <= sum_next;
            s3_used_reg <= s2_used_reg;
            s3_avg_reg  <= prod[DIV_SH +: IMP_W];
            if (s3_used_reg)
            begin
                out_allowed_reg <= allowed;
                out_avg_reg     <= s3_avg_reg;
                out_used_reg    <= 1'b1;
                out_zero_reg    <= (sel_cur == '0);
            end
            else
            begin
                out_allowed_reg <= cfg.unit_default_cur;
                out_avg_reg     <= '0;
                out_used_reg    <= 1'b0;
                out_zero_reg    <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - CUR_W - IMP_W - 2)'(0), out_zero_reg, out_used_reg,
                            out_avg_reg, out_allowed_reg};

`ifndef SYNTHESIS
    // a result without a used reading carries no average and no zero flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[32]) |->
            (m_axis_tdata[31:16] == '0) && !m_axis_tdata[33])
        else $error("unused reading result carries derating fields");

    // the unit default always caps the allowed current
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:0] <= cfg.unit_default_cur))
        else $error("allowed current above unit cap");

    // a new result only comes from a sample request in the last stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s3_valid_reg))
        else $error("result appeared without a sample request");
`endif

endmodule
